>>> rtl/core/vpd_pkg.sv
package vpd_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned NearW  = 31;
  localparam int unsigned DivW   = 32;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages = (DivW + DivBitsPerStage - 1) / DivBitsPerStage;

  localparam logic signed [DataW-1:0] ClipX    = -32'sd5000;
  localparam logic signed [DataW-1:0] ClipXAlt = -32'sd5001;

  localparam logic [NearW-1:0] NearReset = 31'd50;

  typedef enum logic {
    RegNearPlane = 1'b0,
    RegMidDepth  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] depth;
    logic signed [DataW-1:0] vert_x;
    logic signed [DataW-1:0] vert_y;
    logic                    last_in;
  } vpd_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] screen_depth;
    logic signed [DataW-1:0] screen_x;
    logic signed [DataW-1:0] screen_y;
    logic                    last_out;
  } vpd_out_t;

  typedef struct packed {
    logic [DataW-1:0] screen_depth;
    logic             clipped;
    logic             neg_x;
    logic             neg_y;
    logic [DataW-1:0] raw_y;
    logic             last;
  } vpd_side_t;

endpackage

>>> rtl/core/vpd_div_stage.sv
module vpd_div_stage
  import vpd_pkg::*;
(
  input  logic [DivW-1:0] rem_x_i,
  input  logic [DivW-1:0] rem_y_i,
  input  logic [DivW-1:0] num_x_i,
  input  logic [DivW-1:0] num_y_i,
  input  logic [DivW-1:0] quo_x_i,
  input  logic [DivW-1:0] quo_y_i,
  input  logic [DivW-1:0] den_i,
  output logic [DivW-1:0] rem_x_o,
  output logic [DivW-1:0] rem_y_o,
  output logic [DivW-1:0] num_x_o,
  output logic [DivW-1:0] num_y_o,
  output logic [DivW-1:0] quo_x_o,
  output logic [DivW-1:0] quo_y_o
);

  // restoring division, DivBitsPerStage quotient bits per stage for both lanes
  always_comb begin
    logic [DivW:0]   rx, ry;
    logic [DivW-1:0] nx, ny, qx, qy;
    rx = {1'b0, rem_x_i};
    ry = {1'b0, rem_y_i};
    nx = num_x_i;
    ny = num_y_i;
    qx = quo_x_i;
    qy = quo_y_i;
    for (int i = 0; i < DivBitsPerStage; i++) begin
      rx = {rx[DivW-1:0], nx[DivW-1]};
      ry = {ry[DivW-1:0], ny[DivW-1]};
      nx = {nx[DivW-2:0], 1'b0};
      ny = {ny[DivW-2:0], 1'b0};
      if (rx >= {1'b0, den_i}) begin
        rx = rx - {1'b0, den_i};
        qx = {qx[DivW-2:0], 1'b1};
      end else begin
        qx = {qx[DivW-2:0], 1'b0};
      end
      if (ry >= {1'b0, den_i}) begin
        ry = ry - {1'b0, den_i};
        qy = {qy[DivW-2:0], 1'b1};
      end else begin
        qy = {qy[DivW-2:0], 1'b0};
      end
    end
    rem_x_o = rx[DivW-1:0];
    rem_y_o = ry[DivW-1:0];
    num_x_o = nx;
    num_y_o = ny;
    quo_x_o = qx;
    quo_y_o = qy;
  end

endmodule

>>> rtl/core/vertex_perspective_divide.sv
// Throughput: one vertex per cycle while not stalled; a radix-4 restoring
// divider stage per register slice, two lanes (x and y) sharing the divisor.
// Reset: asynchronous, active low; clears all valid bits, near_plane to 50,
// mid_depth to 0. A stall freezes the whole pipeline.
module vertex_perspective_divide
  import vpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DataW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vpd_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vpd_out_t         out_data_o
);

  localparam int unsigned Depth = DivStages + 1;

  logic [NearW-1:0] near_q;
  logic [DataW-1:0] mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NearReset;
      mid_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegNearPlane: near_q <= cfg_data_i[NearW-1:0];
        RegMidDepth:  mid_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic [Depth:0] vld_q;
  assign adv        = !vld_q[Depth] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[Depth];

  logic [DivW-1:0] rx_q [Depth], ry_q [Depth], nx_q [Depth], ny_q [Depth];
  logic [DivW-1:0] qx_q [Depth], qy_q [Depth], den_q [Depth];
  vpd_side_t       side_q [Depth];

  logic [DivW-1:0] rx_d [DivStages], ry_d [DivStages], nx_d [DivStages];
  logic [DivW-1:0] ny_d [DivStages], qx_d [DivStages], qy_d [DivStages];

  // stage 0: clip decision, magnitudes
  logic [NearW-1:0] near_eff;
  logic             clip0;
  logic [DataW-1:0] ax, ay;
  assign near_eff = (near_q == '0) ? NearW'(1) : near_q;
  assign clip0 = in_data_i.depth[DataW-1] ||
                 (in_data_i.depth[NearW-1:0] < near_eff);
  assign ax = in_data_i.vert_x[DataW-1] ? -in_data_i.vert_x : in_data_i.vert_x;
  assign ay = in_data_i.vert_y[DataW-1] ? -in_data_i.vert_y : in_data_i.vert_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-1:0], in_valid_i};
    end
  end

  // divider slices
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    vpd_div_stage u_stage (
      .rem_x_i (rx_q[s]), .rem_y_i (ry_q[s]),
      .num_x_i (nx_q[s]), .num_y_i (ny_q[s]),
      .quo_x_i (qx_q[s]), .quo_y_i (qy_q[s]),
      .den_i   (den_q[s]),
      .rem_x_o (rx_d[s]), .rem_y_o (ry_d[s]),
      .num_x_o (nx_d[s]), .num_y_o (ny_d[s]),
      .quo_x_o (qx_d[s]), .quo_y_o (qy_d[s])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q[0]  <= '0;
      ry_q[0]  <= '0;
      nx_q[0]  <= ax;
      ny_q[0]  <= ay;
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
      den_q[0] <= in_data_i.depth;
      side_q[0].screen_depth <= in_data_i.depth - mid_q;
      side_q[0].clipped      <= clip0;
      side_q[0].neg_x        <= in_data_i.vert_x[DataW-1];
      side_q[0].neg_y        <= in_data_i.vert_y[DataW-1];
      side_q[0].raw_y        <= in_data_i.vert_y;
      side_q[0].last         <= in_data_i.last_in;
      for (int s = 0; s < DivStages; s++) begin
        rx_q[s+1]   <= rx_d[s];
        ry_q[s+1]   <= ry_d[s];
        nx_q[s+1]   <= nx_d[s];
        ny_q[s+1]   <= ny_d[s];
        qx_q[s+1]   <= qx_d[s];
        qy_q[s+1]   <= qy_d[s];
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  // final: sign, clip and sentinel
  logic [DataW-1:0] sx, sy;
  vpd_out_t         res_d, res_q;
  always_comb begin
    sx = side_q[Depth-1].neg_x ? -qx_q[Depth-1] : qx_q[Depth-1];
    sy = side_q[Depth-1].neg_y ? -qy_q[Depth-1] : qy_q[Depth-1];
    res_d.screen_depth = side_q[Depth-1].screen_depth;
    res_d.last_out     = side_q[Depth-1].last;
    if (side_q[Depth-1].clipped) begin
      res_d.screen_x = ClipX;
      res_d.screen_y = side_q[Depth-1].raw_y;
    end else begin
      res_d.screen_x = (sx == ClipX) ? ClipXAlt : sx;
      res_d.screen_y = sy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

endmodule
